[rtl/cdra_pkg.sv]
`default_nettype none

package cdra_pkg;

	localparam int unsigned DAY_W     = 5;
	localparam int unsigned MONTH_W   = 4;
	localparam int unsigned YEAR_W    = 14;
	localparam int unsigned READING_W = 32;
	localparam int unsigned PAIR_W    = 16;
	localparam int unsigned TOTAL_W   = 48;
	localparam int unsigned SUM_W     = TOTAL_W + 2;

	localparam logic [MONTH_W-1:0] MONTH_JAN     = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB     = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_MAR     = 4'd3;
	localparam logic [MONTH_W-1:0] MONTH_APR     = 4'd4;
	localparam logic [MONTH_W-1:0] MONTH_MAY     = 4'd5;
	localparam logic [MONTH_W-1:0] MONTH_JUN     = 4'd6;
	localparam logic [MONTH_W-1:0] MONTH_JUL     = 4'd7;
	localparam logic [MONTH_W-1:0] MONTH_AUG     = 4'd8;
	localparam logic [MONTH_W-1:0] MONTH_SEP     = 4'd9;
	localparam logic [MONTH_W-1:0] MONTH_OCT     = 4'd10;
	localparam logic [MONTH_W-1:0] MONTH_NOV     = 4'd11;
	localparam logic [MONTH_W-1:0] MONTH_DEC     = 4'd12;
	localparam logic [MONTH_W-1:0] MONTH_WRAP    = 4'd13;

	// inverse of 25 mod 2^12; x divisible by 25 iff (x * inv) mod 2^12 <= 4095 / 25
	localparam int unsigned        Q_W       = YEAR_W - 2;
	localparam logic [Q_W-1:0]     INV25     = 12'd3113;
	localparam logic [Q_W-1:0]     DIV25_LIM = Q_W'((2 ** Q_W - 1) / 25);

	localparam logic [PAIR_W-1:0]  PAIR_MAX  = '1;
	localparam logic signed [TOTAL_W-1:0] TOTAL_MAX = {1'b0, {(TOTAL_W-1){1'b1}}};
	localparam logic signed [TOTAL_W-1:0] TOTAL_MIN = {1'b1, {(TOTAL_W-1){1'b0}}};

	// divisible by 4, and either not by 100 or also by 400
	function automatic logic is_leap(input logic [YEAR_W-1:0] y);
		logic [2*Q_W-1:0] prod;
		logic             div25;
		prod  = y[YEAR_W-1:2] * INV25;
		div25 = (prod[Q_W-1:0] <= DIV25_LIM);
		return (y[1:0] == 2'd0) && (!div25 || (y[3:2] == 2'd0));
	endfunction

	// first day number past the month end; zero for an invalid month
	function automatic logic [DAY_W:0] day_past_end(input logic [MONTH_W-1:0] m, input logic leap);
		logic [DAY_W:0] lim;
		case (m)
			MONTH_FEB: begin
				lim = leap ? 6'd30 : 6'd29;
			end
			MONTH_JAN, MONTH_MAR, MONTH_MAY, MONTH_JUL, MONTH_AUG, MONTH_OCT,
			MONTH_DEC: begin
				lim = 6'd32;
			end
			MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: begin
				lim = 6'd31;
			end
			default: begin
				lim = '0;
			end
		endcase
		return lim;
	endfunction

endpackage

`default_nettype wire

[rtl/consecutive_day_reading_accumulator.sv]
// A result appears on out_valid in the cycle after the transaction that carries last.
// Throughput: one transaction per cycle while in_ready is high; date advance, match and
// the saturating add all fit between the stored previous reading and the output register.
// in_ready drops only while a result is held and out_ready is low.
// Reset (arst_n low, asynchronous) clears the stored date, reading and totals to zero.
`default_nettype none

module consecutive_day_reading_accumulator (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 in_valid,
	output logic                                      in_ready,
	input  wire logic [cdra_pkg::DAY_W-1:0]           day,
	input  wire logic [cdra_pkg::MONTH_W-1:0]         month,
	input  wire logic [cdra_pkg::YEAR_W-1:0]          year,
	input  wire logic [cdra_pkg::READING_W-1:0]       reading,
	input  wire logic                                 first,
	input  wire logic                                 last,
	output logic                                      out_valid,
	input  wire logic                                 out_ready,
	output logic [cdra_pkg::PAIR_W-1:0]               pair_count,
	output logic signed [cdra_pkg::TOTAL_W-1:0]       total_use
);

	logic [cdra_pkg::DAY_W-1:0]          prev_day_q;
	logic [cdra_pkg::MONTH_W-1:0]        prev_month_q;
	logic [cdra_pkg::YEAR_W-1:0]         prev_year_q;
	logic                                prev_leap_q;
	logic [cdra_pkg::READING_W-1:0]      prev_reading_q;
	logic [cdra_pkg::PAIR_W-1:0]         pairs_q;
	logic signed [cdra_pkg::TOTAL_W-1:0] use_q;
	logic                                out_valid_q;
	logic [cdra_pkg::PAIR_W-1:0]         pair_count_q;
	logic signed [cdra_pkg::TOTAL_W-1:0] total_use_q;

	logic                                accept;
	logic [cdra_pkg::DAY_W:0]            next_d;
	logic [cdra_pkg::MONTH_W-1:0]        next_m;
	logic [cdra_pkg::YEAR_W:0]           next_y;
	logic                                roll_day;
	logic                                roll_month;
	logic                                match;
	logic signed [cdra_pkg::READING_W:0] diff;
	logic signed [cdra_pkg::SUM_W-1:0]   sum;
	logic signed [cdra_pkg::TOTAL_W-1:0] sum_sat;
	logic [cdra_pkg::PAIR_W-1:0]         pairs_d;
	logic signed [cdra_pkg::TOTAL_W-1:0] use_d;

	assign accept   = in_valid && in_ready;
	assign in_ready = !out_valid_q || out_ready;

	always_comb begin
		next_d     = {1'b0, prev_day_q} + 6'd1;
		next_m     = prev_month_q;
		roll_day   = (next_d == cdra_pkg::day_past_end(prev_month_q, prev_leap_q));
		if (roll_day) begin
			next_d = 6'd1;
			next_m = prev_month_q + 4'd1;
		end
		roll_month = (next_m == cdra_pkg::MONTH_WRAP);
		if (roll_month) begin
			next_m = cdra_pkg::MONTH_JAN;
		end
		next_y = {1'b0, prev_year_q} + {{cdra_pkg::YEAR_W{1'b0}}, roll_month};
		match  = (next_d == {1'b0, day}) && (next_m == month) && (next_y == {1'b0, year});

		diff    = $signed({1'b0, reading}) - $signed({1'b0, prev_reading_q});
		sum     = cdra_pkg::SUM_W'(use_q) + cdra_pkg::SUM_W'(diff);
		if (sum > cdra_pkg::SUM_W'(cdra_pkg::TOTAL_MAX)) begin
			sum_sat = cdra_pkg::TOTAL_MAX;
		end else if (sum < cdra_pkg::SUM_W'(cdra_pkg::TOTAL_MIN)) begin
			sum_sat = cdra_pkg::TOTAL_MIN;
		end else begin
			sum_sat = sum[cdra_pkg::TOTAL_W-1:0];
		end

		if (first) begin
			pairs_d = '0;
			use_d   = '0;
		end else if (match) begin
			pairs_d = (pairs_q == cdra_pkg::PAIR_MAX) ? pairs_q : pairs_q + 16'd1;
			use_d   = sum_sat;
		end else begin
			pairs_d = pairs_q;
			use_d   = use_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_day_q     <= '0;
			prev_month_q   <= '0;
			prev_year_q    <= '0;
			prev_leap_q    <= 1'b1; // year zero is a leap year
			prev_reading_q <= '0;
			pairs_q        <= '0;
			use_q          <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (accept) begin
				prev_day_q     <= day;
				prev_month_q   <= month;
				prev_year_q    <= year;
				prev_leap_q    <= cdra_pkg::is_leap(year);
				prev_reading_q <= reading;
				pairs_q        <= pairs_d;
				use_q          <= use_d;
			end
			if (accept && last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && last) begin
			pair_count_q <= pairs_d;
			total_use_q  <= use_d;
		end
	end

	assign out_valid  = out_valid_q;
	assign pair_count = pair_count_q;
	assign total_use  = total_use_q;

endmodule

`default_nettype wire

[rtl/cdra_checker.sv]
`default_nettype none

module cdra_checker (
	input wire logic                                 clk,
	input wire logic                                 arst_n,
	input wire logic                                 in_valid,
	input wire logic                                 in_ready,
	input wire logic [cdra_pkg::DAY_W-1:0]           day,
	input wire logic [cdra_pkg::MONTH_W-1:0]         month,
	input wire logic [cdra_pkg::YEAR_W-1:0]          year,
	input wire logic [cdra_pkg::READING_W-1:0]       reading,
	input wire logic                                 first,
	input wire logic                                 last,
	input wire logic                                 out_valid,
	input wire logic                                 out_ready,
	input wire logic [cdra_pkg::PAIR_W-1:0]          pair_count,
	input wire logic signed [cdra_pkg::TOTAL_W-1:0]  total_use
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pair_count) && $stable(total_use))
		else $error("result changed while stalled");

	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	a_single_reading_set: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && first && last |=>
			out_valid && pair_count == '0 && total_use == '0)
		else $error("single-reading set gave nonzero result");

	a_no_spurious_result: assert property (@(posedge clk) disable iff (!arst_n)
		(!out_valid || out_ready) && !(in_valid && in_ready && last) |=> !out_valid)
		else $error("result without a last transaction");

endmodule

bind consecutive_day_reading_accumulator cdra_checker u_cdra_checker (.*);

`default_nettype wire
